// File: sv/conv2d_same_zero_pad_defines.svh
// assertion macros for the 2d convolution block
`ifndef CONV2D_SAME_ZERO_PAD_DEFINES_SVH
`define CONV2D_SAME_ZERO_PAD_DEFINES_SVH
`ifndef SYNTHESIS
// condition holds at every clock edge out of reset
`define C2D_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("c2d check failed");
// condition holds one edge after the trigger
`define C2D_ASSERT_NEXT(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("c2d check failed");
`else
`define C2D_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define C2D_ASSERT_NEXT(label, clk, rst_n, trig, cond)
`endif
`endif

// File: sv/c2d_pkg.sv
// shared constants and types of the 2d convolution block
package c2d_pkg;

    localparam int ROWS      = 32;
    localparam int COLS      = 32;
    localparam int KSIZE     = 3;
    localparam int HALF      = KSIZE / 2;
    localparam int KTAPS     = KSIZE * KSIZE;
    localparam int DELAY     = HALF * COLS + HALF;
    localparam int FRAME_PIX = ROWS * COLS;
    localparam int CHAIN_LEN = 2 * DELAY + 1;

    localparam int POS_W = $clog2(FRAME_PIX + DELAY + 1);
    localparam int R_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int C_W   = (COLS > 1) ? $clog2(COLS) : 1;

    localparam int SAMPLE_W  = 16;
    localparam int PROD_W    = 2 * SAMPLE_W;
    localparam int ROW_SUM_W = PROD_W + $clog2(KSIZE) + 1;
    localparam int SUM_W     = PROD_W + $clog2(KTAPS) + 1;
    localparam int FRAC_BITS = 14;
    localparam int RES_W     = 24;
    localparam int SAT_MAX   = 8388607;
    localparam int SAT_MIN   = -8388608;

    typedef enum logic [1:0] {
        OP_WEIGHT = 2'd0,
        OP_PIXEL  = 2'd1,
        OP_DRAIN  = 2'd2
    } op_t;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef sample_t taps_t [KTAPS];

    typedef struct packed {
        logic [1:0]           operation;
        logic [4:0]           weight_index;
        logic signed [15:0]   weight_value;
        logic signed [15:0]   pixel_value;
    } item_t;

    typedef struct packed {
        logic signed [23:0]   result_value;
        logic [4:0]           out_row;
        logic [4:0]           out_col;
        logic                 last_of_frame;
    } result_t;

    // output pixel travelling down the arithmetic stages
    typedef struct packed {
        logic           valid;
        logic [R_W-1:0] row;
        logic [C_W-1:0] col;
        logic           last;
    } meta_t;

endpackage

// File: sv/conv2d_same_zero_pad.sv
// top level of the streaming 2d convolution with same-size zero padding
//
//  channel   | handshake                    | payload
//  ----------+------------------------------+-------------------------------
//  item      | item_valid / item_ready      | item   (c2d_pkg::item_t)
//  result    | result_valid / result_ready  | result (c2d_pkg::result_t)
//
//  one item per cycle while results are taken; the item completing a window
//  moves its result through the mask, product, row-sum and output registers
//  the whole datapath (sample chain, products, row sums, output register)
//  stalls on one enable: it freezes while a result waits, so item_ready is
//  low only when a result is held and result_ready is low
//  reset clears counters, weights and stage valids; the sample chain is not
//  cleared since taps outside the frame are masked by output position
`include "conv2d_same_zero_pad_defines.svh"

module conv2d_same_zero_pad (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  c2d_pkg::item_t     item,
    output logic               result_valid,
    input  logic               result_ready,
    output c2d_pkg::result_t   result
);

    localparam int RX_W = c2d_pkg::R_W + 4;
    localparam int CX_W = c2d_pkg::C_W + 4;

    // stream position of the next sample, and raster position of next output
    logic [c2d_pkg::POS_W-1:0] pos_reg;
    logic [c2d_pkg::POS_W-1:0] pos_next;
    logic [c2d_pkg::R_W-1:0]   out_r_reg;
    logic [c2d_pkg::R_W-1:0]   out_r_next;
    logic [c2d_pkg::C_W-1:0]   out_c_reg;
    logic [c2d_pkg::C_W-1:0]   out_c_next;

    c2d_pkg::taps_t            weights_reg;
    c2d_pkg::taps_t            weights_next;
    c2d_pkg::taps_t            window;
    c2d_pkg::sample_t          chain [c2d_pkg::CHAIN_LEN];
    c2d_pkg::sample_t          sample;

    c2d_pkg::meta_t            meta_a_reg;
    c2d_pkg::meta_t            meta_a_next;
    logic [c2d_pkg::KTAPS-1:0] mask_a_reg;
    logic [c2d_pkg::KTAPS-1:0] mask_next;
    logic [c2d_pkg::KSIZE-1:0] row_ok;
    logic [c2d_pkg::KSIZE-1:0] col_ok;

    logic advance;
    logic transfer;
    logic is_pixel;
    logic is_drain;
    logic stream;
    logic emit;
    logic frame_last;

    // the output register is the only place a result can wait
    assign advance    = !result_valid || result_ready;
    assign item_ready = advance;
    assign transfer   = item_valid && item_ready;

    // pixels only until the frame is full, drain ticks only after
    assign is_pixel = (item.operation == c2d_pkg::OP_PIXEL)
                   && (pos_reg < c2d_pkg::POS_W'(c2d_pkg::FRAME_PIX));
    assign is_drain = (item.operation == c2d_pkg::OP_DRAIN)
                   && (pos_reg >= c2d_pkg::POS_W'(c2d_pkg::FRAME_PIX));
    assign stream   = transfer && (is_pixel || is_drain);
    assign sample   = is_pixel ? item.pixel_value : '0;

    // an output appears once the window centre has been filled
    assign emit       = stream && (pos_reg >= c2d_pkg::POS_W'(c2d_pkg::DELAY));
    assign frame_last = (out_r_reg == c2d_pkg::R_W'(c2d_pkg::ROWS - 1))
                     && (out_c_reg == c2d_pkg::C_W'(c2d_pkg::COLS - 1));

    always_comb
    begin
        pos_next   = pos_reg;
        out_r_next = out_r_reg;
        out_c_next = out_c_reg;
        if (stream)
        begin
            pos_next = pos_reg + 1'b1;
        end
        if (emit)
        begin
            if (frame_last)
            begin
                // frame done: back to the start of a new one
                pos_next   = '0;
                out_r_next = '0;
                out_c_next = '0;
            end
            else if (out_c_reg == c2d_pkg::C_W'(c2d_pkg::COLS - 1))
            begin
                out_c_next = '0;
                out_r_next = out_r_reg + 1'b1;
            end
            else
            begin
                out_c_next = out_c_reg + 1'b1;
            end
        end
    end

    // weight writes take effect for every output whose window is complete
    // at or after the write, which the lockstep pipeline keeps in order
    always_comb
    begin
        weights_next = weights_reg;
        for (int i = 0; i < c2d_pkg::KTAPS; i++)
        begin
            if (transfer && (item.operation == c2d_pkg::OP_WEIGHT)
                && (item.weight_index == 5'(i)))
            begin
                weights_next[i] = item.weight_value;
            end
        end
    end

    // padding mask from the output position, per kernel row and column
    generate
        for (genvar kr = 0; kr < c2d_pkg::KSIZE; kr++)
        begin : g_row_ok
            assign row_ok[kr] =
                ((RX_W'(out_r_reg) + RX_W'(kr)) >= RX_W'(c2d_pkg::HALF))
             && ((RX_W'(out_r_reg) + RX_W'(kr)) < RX_W'(c2d_pkg::ROWS + c2d_pkg::HALF));
        end
        for (genvar kc = 0; kc < c2d_pkg::KSIZE; kc++)
        begin : g_col_ok
            assign col_ok[kc] =
                ((CX_W'(out_c_reg) + CX_W'(kc)) >= CX_W'(c2d_pkg::HALF))
             && ((CX_W'(out_c_reg) + CX_W'(kc)) < CX_W'(c2d_pkg::COLS + c2d_pkg::HALF));
        end
    endgenerate

    always_comb
    begin
        for (int kr = 0; kr < c2d_pkg::KSIZE; kr++)
        begin
            for (int kc = 0; kc < c2d_pkg::KSIZE; kc++)
            begin
                mask_next[kr * c2d_pkg::KSIZE + kc] = row_ok[kr] && col_ok[kc];
            end
        end
        meta_a_next.valid = emit;
        meta_a_next.row   = out_r_reg;
        meta_a_next.col   = out_c_reg;
        meta_a_next.last  = frame_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            out_r_reg  <= '0;
            out_c_reg  <= '0;
            meta_a_reg <= '0;
            for (int i = 0; i < c2d_pkg::KTAPS; i++)
            begin
                weights_reg[i] <= '0;
            end
        end
        else
        begin
            pos_reg     <= pos_next;
            out_r_reg   <= out_r_next;
            out_c_reg   <= out_c_next;
            weights_reg <= weights_next;
            if (advance)
            begin
                meta_a_reg <= meta_a_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            mask_a_reg <= mask_next;
        end
    end

    // sample chain: cell 0 holds the newest sample, cell k the one k back
    generate
        for (genvar k = 0; k < c2d_pkg::CHAIN_LEN; k++)
        begin : g_chain
            if (k == 0)
            begin : g_head
                c2d_cell u_cell (
                    .clk   (clk),
                    .shift (stream),
                    .d     (sample),
                    .q     (chain[k])
                );
            end
            else
            begin : g_body
                c2d_cell u_cell (
                    .clk   (clk),
                    .shift (stream),
                    .d     (chain[k-1]),
                    .q     (chain[k])
                );
            end
        end
        // window taps sit at fixed places along the chain
        for (genvar kr = 0; kr < c2d_pkg::KSIZE; kr++)
        begin : g_win_row
            for (genvar kc = 0; kc < c2d_pkg::KSIZE; kc++)
            begin : g_win_col
                assign window[kr * c2d_pkg::KSIZE + kc] =
                    chain[(c2d_pkg::KSIZE - 1 - kr) * c2d_pkg::COLS
                          + (c2d_pkg::KSIZE - 1 - kc)];
            end
        end
    endgenerate

    c2d_mac u_mac (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .meta_a       (meta_a_reg),
        .mask_a       (mask_a_reg),
        .window       (window),
        .weights      (weights_reg),
        .result_valid (result_valid),
        .result       (result)
    );

    // stream position never runs past the end of the drain
    `C2D_ASSERT_ALWAYS(a_pos_range, clk, rst_n, pos_reg < c2d_pkg::POS_W'(c2d_pkg::FRAME_PIX + c2d_pkg::DELAY))
    // column counter stays inside the frame
    `C2D_ASSERT_ALWAYS(a_col_range, clk, rst_n, out_c_reg < c2d_pkg::C_W'(c2d_pkg::COLS - 1) || out_c_reg == c2d_pkg::C_W'(c2d_pkg::COLS - 1))
    // the last output of a frame restarts the stream
    `C2D_ASSERT_NEXT(a_frame_restart, clk, rst_n, emit && frame_last, pos_reg == '0 && meta_a_reg.last)
    // no output before the window centre has arrived
    `C2D_ASSERT_NEXT(a_no_early_out, clk, rst_n, stream && pos_reg < c2d_pkg::POS_W'(c2d_pkg::DELAY), !meta_a_reg.valid)

endmodule

// File: sv/c2d_cell.sv
// one shift cell of the sample chain
module c2d_cell (
    input  logic              clk,
    input  logic              shift,
    input  c2d_pkg::sample_t  d,
    output c2d_pkg::sample_t  q
);

    c2d_pkg::sample_t sample_reg;
    c2d_pkg::sample_t sample_next;

    always_comb
    begin
        sample_next = shift ? d : sample_reg;
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
    end

    assign q = sample_reg;

endmodule

// File: sv/c2d_mac.sv
// tap products, row sums, final sum with shift and saturation
module c2d_mac (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  c2d_pkg::meta_t                meta_a,
    input  logic [c2d_pkg::KTAPS-1:0]     mask_a,
    input  c2d_pkg::taps_t                window,
    input  c2d_pkg::taps_t                weights,
    output logic                          result_valid,
    output c2d_pkg::result_t              result
);

    c2d_pkg::meta_t meta_b_reg;
    c2d_pkg::meta_t meta_c_reg;
    logic signed [c2d_pkg::PROD_W-1:0]    prod_b_reg [c2d_pkg::KTAPS];
    logic signed [c2d_pkg::PROD_W-1:0]    prod_b_next [c2d_pkg::KTAPS];
    logic signed [c2d_pkg::ROW_SUM_W-1:0] row_c_reg [c2d_pkg::KSIZE];
    logic signed [c2d_pkg::ROW_SUM_W-1:0] row_c_next [c2d_pkg::KSIZE];
    logic signed [c2d_pkg::SUM_W-1:0]     total;
    logic signed [c2d_pkg::SUM_W-1:0]     shifted;
    logic signed [c2d_pkg::RES_W-1:0]     sat_value;
    logic                                 result_valid_reg;
    c2d_pkg::result_t                     result_reg;
    c2d_pkg::result_t                     result_next;

    // masked products, padding taps read as zero
    always_comb
    begin
        for (int i = 0; i < c2d_pkg::KTAPS; i++)
        begin
            if (mask_a[i])
            begin
                prod_b_next[i] = window[i] * weights[i];
            end
            else
            begin
                prod_b_next[i] = '0;
            end
        end
    end

    always_comb
    begin
        for (int kr = 0; kr < c2d_pkg::KSIZE; kr++)
        begin
            row_c_next[kr] = '0;
            for (int kc = 0; kc < c2d_pkg::KSIZE; kc++)
            begin
                row_c_next[kr] = row_c_next[kr]
                    + c2d_pkg::ROW_SUM_W'(prod_b_reg[kr * c2d_pkg::KSIZE + kc]);
            end
        end
    end

    always_comb
    begin
        total = '0;
        for (int kr = 0; kr < c2d_pkg::KSIZE; kr++)
        begin
            total = total + c2d_pkg::SUM_W'(row_c_reg[kr]);
        end
        shifted = total >>> c2d_pkg::FRAC_BITS;
        if (shifted > c2d_pkg::SUM_W'(c2d_pkg::SAT_MAX))
        begin
            sat_value = c2d_pkg::RES_W'(c2d_pkg::SAT_MAX);
        end
        else if (shifted < c2d_pkg::SUM_W'(c2d_pkg::SAT_MIN))
        begin
            sat_value = c2d_pkg::RES_W'(c2d_pkg::SAT_MIN);
        end
        else
        begin
            sat_value = c2d_pkg::RES_W'(shifted);
        end
        result_next.result_value  = sat_value;
        result_next.out_row       = 5'(meta_c_reg.row);
        result_next.out_col       = 5'(meta_c_reg.col);
        result_next.last_of_frame = meta_c_reg.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            meta_b_reg       <= '0;
            meta_c_reg       <= '0;
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            meta_b_reg       <= meta_a;
            meta_c_reg       <= meta_b_reg;
            result_valid_reg <= meta_c_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prod_b_reg <= prod_b_next;
            row_c_reg  <= row_c_next;
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// File: tb/testbench.sv
// self-checking testbench for the streaming 2d convolution with same-size zero padding
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import c2d_pkg::*;

    // samples that can still fall inside a window: (KSIZE-1) lines plus KSIZE
    localparam int RING_DEPTH    = (KSIZE - 1) * COLS + KSIZE;
    // generous ceiling: ~1300 items, each with the longest gap and result stall
    localparam int CYCLE_LIMIT   = 200000;
    // after the last expected result, leave room for a stray result
    localparam int SETTLE_CYCLES = 16;
    // the one operation code the block does not define
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic    clk = 1'b0;
    logic    rst_n;
    logic    item_valid;
    logic    item_ready;
    item_t   item;
    logic    result_valid;
    logic    result_ready;
    result_t result;

    // mirror of the block: taps, recent samples and raster position
    sample_t     weight_taps [KTAPS];
    sample_t     sample_ring [RING_DEPTH];
    int unsigned in_row = 0;
    int unsigned in_col = 0;
    result_t     expected_pixels [$];

    int error_count = 0;
    int cycle_count = 0;
    int sent_items  = 0;
    int stall_left  = 0;
    // set for the closing stretch: no gaps on either side
    bit calm        = 1'b0;

    conv2d_same_zero_pad i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // run-away guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    // updates the mirror with one accepted item and queues the output pixel
    // that it completes, if any
    function automatic void track_conv_item(input item_t it);
        int unsigned pos;
        int          o;
        int          r;
        int          c;
        int          rr;
        int          cc;
        sample_t     s;
        longint      acc;
        result_t     res;
        pos = in_row * COLS + in_col;
        if (it.operation == OP_WEIGHT)
        begin
            // taps beyond the kernel are dropped, the rest apply at once
            if (it.weight_index < KTAPS)
                weight_taps[it.weight_index] = it.weight_value;
            return;
        end
        // pixels only until the frame is full, drain ticks only after it
        if (it.operation == OP_PIXEL && pos < FRAME_PIX)
            s = it.pixel_value;
        else if (it.operation == OP_DRAIN && pos >= FRAME_PIX)
            s = '0;
        else
            return;
        sample_ring[pos % RING_DEPTH] = s;
        in_col++;
        if (in_col == COLS)
        begin
            in_col = 0;
            in_row++;
        end
        // no window is complete until DELAY further samples have arrived
        if (pos < DELAY)
            return;
        o   = pos - DELAY;
        r   = o / COLS;
        c   = o % COLS;
        acc = 0;
        for (int kr = 0; kr < KSIZE; kr++)
        begin
            for (int kc = 0; kc < KSIZE; kc++)
            begin
                rr = r + kr - HALF;
                cc = c + kc - HALF;
                // taps off the frame edge see zero padding
                if (rr >= 0 && rr < ROWS && cc >= 0 && cc < COLS)
                    acc += longint'(sample_ring[(rr * COLS + cc) % RING_DEPTH]) *
                           longint'(weight_taps[kr * KSIZE + kc]);
            end
        end
        // Q.22 down to Q.8 with floor, then clamp to 24 bits
        acc = acc >>> FRAC_BITS;
        if (acc > SAT_MAX)
            acc = SAT_MAX;
        else if (acc < SAT_MIN)
            acc = SAT_MIN;
        res.result_value  = acc[RES_W-1:0];
        res.out_row       = r[4:0];
        res.out_col       = c[4:0];
        res.last_of_frame = (o == FRAME_PIX - 1);
        // the final pixel sends the block back to the top of a new frame
        if (res.last_of_frame)
        begin
            in_row = 0;
            in_col = 0;
        end
        expected_pixels.push_back(res);
    endfunction

    // 16-bit value biased towards the corners of the range
    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 11))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'h0000;
            3:       return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    // item of the given operation with every other field random
    function automatic item_t random_fields(input logic [1:0] op);
        item_t it;
        it.operation    = op;
        it.weight_index = 5'($urandom);
        it.weight_value = pick_word();
        it.pixel_value  = pick_word();
        return it;
    endfunction

    function automatic item_t weight_item(input logic [4:0] idx, input logic [15:0] value);
        item_t it;
        it              = random_fields(OP_WEIGHT);
        it.weight_index = idx;
        it.weight_value = value;
        return it;
    endfunction

    // one transfer on the item channel; entered and left at a falling edge
    task automatic send_item(input item_t it);
        // every third stretch of 50 items runs without gaps
        if (!calm && (sent_items / 50) % 3 != 0 && $urandom_range(0, 3) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (!item_ready);
        track_conv_item(it);
        sent_items++;
        @(negedge clk);
    endtask

    // something other than a counted sample: a tap write, the unused code,
    // or a drain tick / pixel that arrives in the wrong phase
    task automatic send_noise(input bit in_frame);
        case ($urandom_range(0, 3))
            0, 1:
            begin
                if ($urandom_range(0, 7) == 0)
                    send_item(weight_item(5'($urandom), pick_word()));
                else
                    send_item(weight_item(5'($urandom_range(0, KTAPS - 1)), pick_word()));
            end
            2:       send_item(random_fields(OP_UNUSED));
            default: send_item(random_fields(in_frame ? OP_DRAIN : OP_PIXEL));
        endcase
    endtask

    task automatic run_pixels(input int count);
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 15) == 0)
                send_noise(1'b1);
            send_item(random_fields(OP_PIXEL));
        end
    endtask

    // every tap at an extreme or a power-of-two value, then writes past the kernel
    task automatic test_weight_writes();
        logic [15:0] corner_values [KTAPS];
        corner_values = '{16'h8000, 16'h7fff, 16'h4000, 16'hc000, 16'h0001,
                          16'hffff, 16'h2000, 16'he000, 16'h1000};
        for (int k = 0; k < KTAPS; k++)
            send_item(weight_item(5'(k), corner_values[k]));
        send_item(weight_item(5'(KTAPS), 16'h7fff));
        send_item(weight_item(5'd24, 16'h8000));
        send_item(weight_item(5'd31, 16'h7fff));
    endtask

    // unused code with every bit set, and a drain tick before any pixel
    task automatic test_ignored_items();
        send_item('1);
        send_item(random_fields(OP_DRAIN));
    endtask

    // one whole frame with noise, surplus pixels, then the drain ticks
    task automatic test_full_frame();
        logic [15:0] corner_pixels [4];
        item_t       it;
        corner_pixels = '{16'h7fff, 16'h8000, 16'h0000, 16'hffff};
        foreach (corner_pixels[k])
        begin
            it             = random_fields(OP_PIXEL);
            it.pixel_value = corner_pixels[k];
            send_item(it);
        end
        run_pixels(FRAME_PIX - 4);
        // frame full: these pixels must be dropped
        for (int n = 0; n < 3; n++)
            send_item(random_fields(OP_PIXEL));
        for (int n = 0; n < DELAY; n++)
        begin
            if ($urandom_range(0, 5) == 0)
                send_noise(1'b0);
            send_item(random_fields(OP_DRAIN));
        end
    endtask

    // start of a second frame: padding at the top again, no idling
    task automatic test_next_frame();
        calm = 1'b1;
        run_pixels(160);
    endtask

    // result side: ready drops in bursts, which start only outside the calm stretch
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            result_ready <= 1'b0;
            stall_left--;
        end
        else if (!calm && $urandom_range(0, 4) == 0)
        begin
            result_ready <= 1'b0;
            stall_left = $urandom_range(0, 3);
        end
        else
            result_ready <= 1'b1;
    end

    // every result transfer is matched against the oldest expected pixel
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_pixels.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got %p", $time, result);
                error_count++;
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (result.result_value !== want.result_value)
                begin
                    $display("%0t: result_value expected %0d got %0d",
                             $time, want.result_value, result.result_value);
                    error_count++;
                end
                if (result.out_row !== want.out_row)
                begin
                    $display("%0t: out_row expected %0d got %0d",
                             $time, want.out_row, result.out_row);
                    error_count++;
                end
                if (result.out_col !== want.out_col)
                begin
                    $display("%0t: out_col expected %0d got %0d",
                             $time, want.out_col, result.out_col);
                    error_count++;
                end
                if (result.last_of_frame !== want.last_of_frame)
                begin
                    $display("%0t: last_of_frame expected %0b got %0b",
                             $time, want.last_of_frame, result.last_of_frame);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        result_ready = 1'b0;
        foreach (weight_taps[k])
            weight_taps[k] = '0;
        foreach (sample_ring[k])
            sample_ring[k] = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_weight_writes();
        test_ignored_items();
        test_full_frame();
        test_next_frame();

        // stop sending, let every outstanding pixel arrive, then settle
        item_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
